/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dcc_pkg.sv */
// ----------------------------------------------------------------------------
// dcc_pkg
// Types, constants and helper functions of the day count to date converter.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int DAY_COUNT_BITS = 17;
  localparam int YEAR_BITS      = 12;
  localparam int MONTH_BITS     = 4;
  localparam int DAY_BITS       = 5;

  localparam int EPOCH_YEAR = 1970;

  typedef logic [DAY_COUNT_BITS-1:0] day_cnt_t;
  typedef logic [YEAR_BITS-1:0]      year_t;
  typedef logic [MONTH_BITS-1:0]     month_t;
  typedef logic [DAY_BITS-1:0]       dom_t;
  typedef logic [8:0]                ylen_t;
  typedef logic [1:0]                mod4_t;
  typedef logic [6:0]                mod100_t;
  typedef logic [8:0]                mod400_t;

  localparam ylen_t   YEAR_DAYS   = 9'd365;
  localparam month_t  LAST_MONTH  = 4'd11;
  localparam month_t  FEB_IDX     = 4'd1;

  // Residues of the epoch year, advanced by one with every year stepped.
  localparam mod4_t   MOD4_INIT   = mod4_t'(EPOCH_YEAR % 4);
  localparam mod100_t MOD100_INIT = mod100_t'(EPOCH_YEAR % 100);
  localparam mod400_t MOD400_INIT = mod400_t'(EPOCH_YEAR % 400);
  localparam mod100_t MOD100_LAST = mod100_t'(99);
  localparam mod400_t MOD400_LAST = mod400_t'(399);

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
  } dcc_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } dcc_sts_t;

  function automatic dom_t month_len(input month_t idx, input logic leap);
    dom_t len;
    case (idx)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hdl/day_count_to_calendar_date_top.sv */
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_top
// Converts a day count since the 1970 epoch into a Gregorian date.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The block then steps
// one calendar year per cycle, subtracting 365 or 366 days, and afterwards one
// month per cycle. The result is registered and appears on the out_ ports
// after the year steps, the move to month stepping, the month steps and the
// return to idle. No new item is taken while busy is high, so items do not
// overlap: the next one can start only once this result is shown. The result
// is shown for exactly one cycle with out_valid high and cannot be held off,
// so the receiver must take it in that cycle. busy is already low during
// that cycle, and a new item may be started in it. Count 0 gives 1970-01-00.

module day_count_to_calendar_date_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dcc_pkg::DAY_COUNT_BITS-1:0] in_day_count,
  output logic                         out_valid,
  output logic [dcc_pkg::YEAR_BITS-1:0]  out_year,
  output logic [dcc_pkg::MONTH_BITS-1:0] out_month,
  output logic [dcc_pkg::DAY_BITS-1:0]   out_day_of_month
);

  dcc_pkg::dcc_cmd_t cmd;
  dcc_pkg::dcc_sts_t sts;

  dcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  dcc_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .day_count    (in_day_count),
    .cmd          (cmd),
    .sts          (sts),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month)
  );

endmodule

/* hdl/dcc_datapath.sv */
// ----------------------------------------------------------------------------
// dcc_datapath
// Remaining-day register, year counter with leap residues, and month index.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcc_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dcc_pkg::day_cnt_t         day_count,
  input  dcc_pkg::dcc_cmd_t         cmd,
  output dcc_pkg::dcc_sts_t         sts,
  output dcc_pkg::year_t            year,
  output dcc_pkg::month_t           month,
  output dcc_pkg::dom_t             day_of_month
);

  dcc_pkg::day_cnt_t rest_r, rest_nxt;
  dcc_pkg::year_t    year_r, year_nxt;
  dcc_pkg::mod4_t    mod4_r, mod4_nxt;
  dcc_pkg::mod100_t  mod100_r, mod100_nxt;
  dcc_pkg::mod400_t  mod400_r, mod400_nxt;
  dcc_pkg::month_t   mon_r, mon_nxt;

  logic              leap;
  dcc_pkg::ylen_t    ylen;
  dcc_pkg::dom_t     mlen;

  // Leap year: divisible by 400, or by 4 but not by 100.
  assign leap = (mod400_r == '0) || ((mod100_r != '0) && (mod4_r == '0));
  assign ylen = dcc_pkg::YEAR_DAYS + dcc_pkg::ylen_t'(leap);
  assign mlen = dcc_pkg::month_len(mon_r, leap);

  assign sts.year_more  = rest_r > dcc_pkg::day_cnt_t'(ylen);
  assign sts.month_more = (rest_r > dcc_pkg::day_cnt_t'(mlen)) &&
                          (mon_r < dcc_pkg::LAST_MONTH);

  always_comb begin
    rest_nxt   = rest_r;
    year_nxt   = year_r;
    mod4_nxt   = mod4_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    mon_nxt    = mon_r;
    if (cmd.load) begin
      rest_nxt   = day_count;
      year_nxt   = dcc_pkg::year_t'(dcc_pkg::EPOCH_YEAR);
      mod4_nxt   = dcc_pkg::MOD4_INIT;
      mod100_nxt = dcc_pkg::MOD100_INIT;
      mod400_nxt = dcc_pkg::MOD400_INIT;
      mon_nxt    = '0;
    end else if (cmd.year_step) begin
      rest_nxt   = rest_r - dcc_pkg::day_cnt_t'(ylen);
      year_nxt   = year_r + 1'b1;
      mod4_nxt   = mod4_r + 1'b1;
      mod100_nxt = (mod100_r == dcc_pkg::MOD100_LAST) ? '0 : mod100_r + 1'b1;
      mod400_nxt = (mod400_r == dcc_pkg::MOD400_LAST) ? '0 : mod400_r + 1'b1;
    end else if (cmd.month_step) begin
      rest_nxt = rest_r - dcc_pkg::day_cnt_t'(mlen);
      mon_nxt  = mon_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rest_r   <= rest_nxt;
    year_r   <= year_nxt;
    mod4_r   <= mod4_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
    mon_r    <= mon_nxt;
  end

  assign year         = year_r;
  assign month        = mon_r + 1'b1;
  assign day_of_month = rest_r[dcc_pkg::DAY_BITS-1:0];

  `DCC_ASSERT_SAME(a_month_step_in_range, cmd.month_step, mon_r < dcc_pkg::LAST_MONTH, "month step past December")
  `DCC_ASSERT_NEXT(a_year_step_shrinks, cmd.year_step, rest_r < $past(rest_r), "year step did not reduce remaining days")

endmodule

/* hdl/dcc_ctrl.sv */
// ----------------------------------------------------------------------------
// dcc_ctrl
// Sequencer: load, step years, step months, then strobe the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  dcc_pkg::dcc_sts_t  sts,
  output dcc_pkg::dcc_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_YEAR  = 2'd1;
  localparam logic [1:0] S_MONTH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       done_r, done_nxt;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sts.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (sts.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;

  `DCC_ASSERT_NEXT(a_done_single, done_r, !done_r, "result strobe lasted more than one cycle")
  `DCC_ASSERT_NEXT(a_start_enters_year, start && !busy, state_r == S_YEAR, "accepted item did not start year stepping")
  `DCC_ASSERT_SAME(a_done_when_idle, done_r, state_r == S_IDLE, "result strobe outside idle")

endmodule
